### rtl/core/illcs_pkg.sv
`default_nettype none

package illcs_pkg;

	localparam int MAX_CORES_DEF  = 16;
	localparam int NUM_IRQS_DEF   = 16;
	localparam int COUNT_BITS_DEF = 32;

	localparam int CFG_INDEX_BITS = 8;
	localparam int CFG_DATA_BITS  = 16;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_SYMMETRIC_IO_MODE = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BALANCING_ENABLE  = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CORE_COUNT        = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BALANCE_PERIOD    = 8'd3;

	localparam logic [4:0]  CORE_COUNT_RESET     = 5'd1;
	localparam logic [15:0] BALANCE_PERIOD_RESET = 16'd10;

	typedef struct packed {
		logic [3:0] irq_number;
		logic [3:0] core_id;
	} in_t;

	typedef struct packed {
		logic       eoi_to_local;
		logic [3:0] eoi_irq;
		logic       route_valid;
		logic [3:0] route_core;
		logic       counters_cleared;
	} out_t;

endpackage

`default_nettype wire

### rtl/core/illcs_ram.sv
`default_nettype none

module illcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/core/irq_least_loaded_core_steering.sv
`default_nettype none

// Serviced-interrupt load balancer. Every accepted item gives exactly one result. An item whose
// IRQ or core is out of range goes from accept straight to result; one that arrives with
// balancing disabled passes accept, read, counter update and result. With balancing enabled, the
// period check runs after the counter update as a restoring remainder over the new count, one bit
// per cycle. When the count is a multiple of the period, a minimum scan follows: one
// counter-memory read per core. If the IRQ's counters must be cleared, zeros are then written for
// all MAX_CORES cores through the single memory write port. A result that the receiver holds off
// stretches the step until the output register frees up. After reset the block clears the whole
// counter memory, one entry per cycle (2**(clog2(MAX_CORES)+clog2(NUM_IRQS)) entries, 256 by
// default), and accepts no item until that is done. Configuration writes are accepted on every
// cycle. A new item is taken while the previous result still waits in the output register.
module irq_least_loaded_core_steering #(
	parameter int MAX_CORES  = illcs_pkg::MAX_CORES_DEF,
	parameter int NUM_IRQS   = illcs_pkg::NUM_IRQS_DEF,
	parameter int COUNT_BITS = illcs_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire illcs_pkg::in_t                      in_item,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output illcs_pkg::out_t                          out_item,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [illcs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [illcs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int CW    = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
	localparam int IW    = (NUM_IRQS > 1) ? $clog2(NUM_IRQS) : 1;
	localparam int AW    = CW + IW;
	localparam int DEPTH = 1 << AW;
	localparam int NW    = $clog2(MAX_CORES + 1);
	localparam int BW    = $clog2(COUNT_BITS);

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_UPD,
		ST_DIV,
		ST_SCAN,
		ST_CLR,
		ST_DONE
	} state_t;

	// configuration registers
	logic        sym_mode_q;
	logic        bal_en_q;
	logic [4:0]  core_count_q;
	logic [15:0] period_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_mode_q   <= 1'b0;
			bal_en_q     <= 1'b0;
			core_count_q <= illcs_pkg::CORE_COUNT_RESET;
			period_q     <= illcs_pkg::BALANCE_PERIOD_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				illcs_pkg::CFG_SYMMETRIC_IO_MODE: sym_mode_q   <= cfg_data[0];
				illcs_pkg::CFG_BALANCING_ENABLE:  bal_en_q     <= cfg_data[0];
				illcs_pkg::CFG_CORE_COUNT:        core_count_q <= cfg_data[4:0];
				illcs_pkg::CFG_BALANCE_PERIOD:    period_q     <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	state_t                state_q;
	logic [AW-1:0]         init_q;
	logic [IW-1:0]         irq_q;
	logic [CW-1:0]         core_q;
	illcs_pkg::out_t       res_q;
	illcs_pkg::out_t       out_item_q;
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] div_q;
	logic [15:0]           rem_q;
	logic [BW-1:0]         bit_q;
	logic [NW-1:0]         iss_q;
	logic                  pend_s1;
	logic [CW-1:0]         idx_s1;
	logic [COUNT_BITS-1:0] minv_q;
	logic [CW-1:0]         mini_q;
	logic                  clr_need_q;

	// counter memory
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [COUNT_BITS-1:0] ram_rdata;

	illcs_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(DEPTH)
	) u_counts (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	logic [COUNT_BITS-1:0] new_cnt;
	logic [15:0]           period_eff;
	logic [16:0]           rem_shift;
	logic [16:0]           rem_sub;
	logic [15:0]           rem_next;
	logic [8:0]            cc_ext;
	logic [NW-1:0]         n_eff;
	logic                  issue;
	logic                  in_range;

	always_comb begin
		new_cnt    = (&ram_rdata) ? ram_rdata : ram_rdata + 1'b1;
		period_eff = (period_q == 16'd0) ? 16'd1 : period_q;

		// one restoring remainder step
		rem_shift = {rem_q, div_q[COUNT_BITS-1]};
		rem_sub   = rem_shift - {1'b0, period_eff};
		rem_next  = (rem_shift >= {1'b0, period_eff}) ? rem_sub[15:0] : rem_shift[15:0];

		cc_ext = 9'(core_count_q);
		if (cc_ext == 9'd0) begin
			n_eff = NW'(1);
		end else if (cc_ext > 9'(MAX_CORES)) begin
			n_eff = NW'(MAX_CORES);
		end else begin
			n_eff = NW'(cc_ext);
		end
		issue = (iss_q < n_eff);

		in_range = (9'(in_item.irq_number) < 9'(NUM_IRQS))
			&& (9'(in_item.core_id) < 9'(MAX_CORES));
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {core_q, irq_q};
		ram_wdata = '0;
		ram_raddr = {core_q, irq_q};
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = init_q;
			end
			ST_UPD: begin
				ram_we    = 1'b1;
				ram_wdata = new_cnt;
			end
			ST_SCAN: begin
				ram_raddr = {iss_q[CW-1:0], irq_q};
			end
			ST_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = {iss_q[CW-1:0], irq_q};
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_q      <= '0;
			out_valid_q <= 1'b0;
			pend_s1     <= 1'b0;
			iss_q       <= '0;
			bit_q       <= '0;
			clr_need_q  <= 1'b0;
			irq_q       <= '0;
			core_q      <= '0;
			res_q       <= '0;
			out_item_q  <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			idx_s1      <= '0;
			minv_q      <= '0;
			mini_q      <= '0;
		end else begin
			// in ST_DONE the output register is refilled instead
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (&init_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						irq_q                  <= IW'(in_item.irq_number);
						core_q                 <= CW'(in_item.core_id);
						res_q.eoi_to_local     <= sym_mode_q;
						res_q.eoi_irq          <= in_item.irq_number;
						res_q.route_valid      <= 1'b0;
						res_q.route_core       <= 4'd0;
						res_q.counters_cleared <= 1'b0;
						state_q                <= in_range ? ST_RD : ST_DONE;
					end
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					div_q   <= new_cnt;
					rem_q   <= '0;
					bit_q   <= BW'(COUNT_BITS - 1);
					state_q <= bal_en_q ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					rem_q <= rem_next;
					div_q <= div_q << 1;
					bit_q <= bit_q - 1'b1;
					if (bit_q == '0) begin
						iss_q      <= '0;
						pend_s1    <= 1'b0;
						minv_q     <= '1;
						mini_q     <= '0;
						clr_need_q <= 1'b0;
						state_q    <= (rem_next == 16'd0) ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					// reads issue one core ahead of the compare
					pend_s1 <= issue;
					if (issue) begin
						iss_q  <= iss_q + 1'b1;
						idx_s1 <= iss_q[CW-1:0];
					end
					if (pend_s1) begin
						if (ram_rdata < minv_q) begin
							minv_q <= ram_rdata;
							mini_q <= idx_s1;
						end else if (&ram_rdata[COUNT_BITS-1:1]) begin
							clr_need_q <= 1'b1;
						end
					end
					if (!issue && !pend_s1) begin
						res_q.route_valid <= 1'b1;
						res_q.route_core  <= 4'(mini_q);
						if (clr_need_q) begin
							res_q.counters_cleared <= 1'b1;
							iss_q                  <= '0;
							state_q                <= ST_CLR;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CLR: begin
					iss_q <= iss_q + 1'b1;
					if (iss_q == NW'(MAX_CORES - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_item_q  <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
